@@ hdl/hvps_pkg.sv @@
package hvps_pkg;

    localparam int MAX_DIGITS = 5;
    localparam int ACC_W      = 17;
    localparam int CNT_W      = 3;
    localparam int ADDR_W     = 3;

    localparam logic [ACC_W-1:0] ACC_MAX = 17'd131071;

    localparam logic [7:0] CH_V    = 8'h56;
    localparam logic [7:0] CH_H    = 8'h48;
    localparam logic [7:0] CH_ZERO = 8'h30;
    localparam logic [7:0] CH_NINE = 8'h39;

    localparam logic REG_INV = 1'b0;
    localparam logic REG_CLK = 1'b1;

    localparam logic [27:0] CLK_RESET     = 28'd125000000;
    localparam logic [14:0] OFF_WRAP      = 15'd6249;
    localparam logic [14:0] OFF_LEVEL_INV = 15'd6429;

    // floor(x/100) = (x*RECIP_100) >> RECIP_SH for x below 2^21
    localparam int          RECIP_SH  = 28;
    localparam logic [21:0] RECIP_100 = 22'd2684355;

    typedef struct packed {
        logic       ok;
        logic [4:0] kv;
        logic [8:0] khz;
    } t_req;

    function automatic logic [9:0] grad_milli(input logic [4:0] k);
        case (k)
            5'd0:  grad_milli = 10'd787;
            5'd1:  grad_milli = 10'd738;
            5'd2:  grad_milli = 10'd672;
            5'd3:  grad_milli = 10'd639;
            5'd4:  grad_milli = 10'd618;
            5'd5:  grad_milli = 10'd571;
            5'd6:  grad_milli = 10'd505;
            5'd7:  grad_milli = 10'd503;
            5'd8:  grad_milli = 10'd457;
            5'd9:  grad_milli = 10'd443;
            5'd10: grad_milli = 10'd403;
            5'd11: grad_milli = 10'd394;
            5'd12: grad_milli = 10'd372;
            5'd13: grad_milli = 10'd354;
            5'd14: grad_milli = 10'd339;
            5'd15: grad_milli = 10'd323;
            5'd16: grad_milli = 10'd357;
            5'd17: grad_milli = 10'd346;
            5'd18: grad_milli = 10'd353;
            5'd19: grad_milli = 10'd345;
            5'd20: grad_milli = 10'd327;
            default: grad_milli = 10'd787;
        endcase
    endfunction

    function automatic logic [11:0] icpt_milli(input logic [4:0] k);
        case (k)
            5'd0:  icpt_milli = 12'd2992;
            5'd1:  icpt_milli = 12'd3148;
            5'd2:  icpt_milli = 12'd3000;
            5'd3:  icpt_milli = 12'd2946;
            5'd4:  icpt_milli = 12'd3294;
            5'd5:  icpt_milli = 12'd3294;
            5'd6:  icpt_milli = 12'd2330;
            5'd7:  icpt_milli = 12'd3045;
            5'd8:  icpt_milli = 12'd2259;
            5'd9:  icpt_milli = 12'd2244;
            5'd10: icpt_milli = 12'd1505;
            5'd11: icpt_milli = 12'd2161;
            5'd12: icpt_milli = 12'd1650;
            5'd13: icpt_milli = 12'd1442;
            5'd14: icpt_milli = 12'd1412;
            5'd15: icpt_milli = 12'd1483;
            5'd16: icpt_milli = 12'd2594;
            5'd17: icpt_milli = 12'd2436;
            5'd18: icpt_milli = 12'd3067;
            5'd19: icpt_milli = 12'd2714;
            5'd20: icpt_milli = 12'd2411;
            default: icpt_milli = 12'd2992;
        endcase
    endfunction

endpackage

@@ hdl/hvps_front.sv @@
module hvps_front
    import hvps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_rx_byte,
    output logic       o_push,
    output t_req       o_req
);

    logic             r_phase;
    logic [ACC_W-1:0] r_vacc;
    logic [ACC_W-1:0] r_facc;
    logic [CNT_W-1:0] r_vcnt;
    logic [CNT_W-1:0] r_fcnt;
    logic             r_bad;

    logic             is_digit;
    logic [3:0]       digit;
    logic [ACC_W-1:0] cur_acc;
    logic [CNT_W-1:0] cur_cnt;
    logic [20:0]      acc_x10;
    logic [ACC_W-1:0] acc_sat;
    logic             over;

    assign is_digit = (i_rx_byte >= CH_ZERO) && (i_rx_byte <= CH_NINE);
    assign digit    = 4'(i_rx_byte - CH_ZERO);
    assign cur_acc  = r_phase ? r_facc : r_vacc;
    assign cur_cnt  = r_phase ? r_fcnt : r_vcnt;
    assign acc_x10  = 21'(cur_acc) * 21'd10 + 21'(digit);
    assign acc_sat  = (acc_x10 > 21'(ACC_MAX)) ? ACC_MAX : acc_x10[ACC_W-1:0];
    assign over     = cur_cnt >= CNT_W'(MAX_DIGITS);

    assign o_push    = i_take && (i_rx_byte == CH_H);
    assign o_req.ok  = r_phase && !r_bad &&
                       (r_vacc >= 17'd5) && (r_vacc <= 17'd20) &&
                       (r_facc >= 17'd10) && (r_facc <= 17'd300);
    assign o_req.kv  = r_vacc[4:0];
    assign o_req.khz = r_facc[8:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_phase <= 1'b0;
            r_vacc  <= '0;
            r_facc  <= '0;
            r_vcnt  <= '0;
            r_fcnt  <= '0;
            r_bad   <= 1'b0;
        end else if (i_take) begin
            if (is_digit) begin
                if (over) begin
                    r_bad <= 1'b1;
                end else if (r_phase) begin
                    r_facc <= acc_sat;
                    r_fcnt <= r_fcnt + 1'b1;
                end else begin
                    r_vacc <= acc_sat;
                    r_vcnt <= r_vcnt + 1'b1;
                end
            end else if (i_rx_byte == CH_V && !r_phase) begin
                r_phase <= 1'b1;
            end else begin
                r_bad <= 1'b1;
            end
        end
    end

endmodule

@@ hdl/hvps_queue.sv @@
module hvps_queue
    import hvps_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_req i_req,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_req o_req
);

    t_req       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_req   = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

@@ hdl/hvps_back.sv @@
module hvps_back
    import hvps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_inv,
    input  logic [27:0] i_clock_hz,
    input  logic        i_q_valid,
    input  t_req        i_q_req,
    output logic        o_q_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [14:0] o_period_wrap,
    output logic [14:0] o_compare_level,
    output logic [5:0]  o_duty_percent,
    output logic        o_supply_off,
    output logic [4:0]  o_volts_kv,
    output logic [8:0]  o_freq_khz
);

    typedef enum logic [2:0] {
        S_IDLE, S_DIVP, S_DIVD, S_MUL, S_SCALE, S_LEVEL, S_FIN
    } t_state;

    t_state      r_state;
    logic [27:0] r_quo;
    logic [18:0] r_rem;
    logic [18:0] r_den;
    logic [4:0]  r_cnt;
    logic [14:0] r_num;
    logic [9:0]  r_grad;
    logic        r_hit;
    logic [4:0]  r_kv;
    logic [8:0]  r_khz;
    logic [14:0] r_period;
    logic [5:0]  r_duty;
    logic [20:0] r_prod;
    logic [42:0] r_scaled;
    logic [14:0] r_res_wrap;
    logic [14:0] r_res_level;
    logic [5:0]  r_res_duty;
    logic        r_res_off;
    logic        r_valid;

    logic [19:0] trial;
    logic        ge;
    logic [18:0] rem_nx;
    logic [27:0] quo_nx;
    logic [4:0]  tk;
    logic        last;
    logic [5:0]  limit;
    logic [14:0] on_cnt;
    logic        out_free;

    assign trial    = {r_rem, r_quo[27]};
    assign ge       = trial >= {1'b0, r_den};
    assign rem_nx   = ge ? 19'(trial - {1'b0, r_den}) : trial[18:0];
    assign quo_nx   = {r_quo[26:0], ge};
    assign last     = r_cnt == 5'd27;
    assign tk       = 5'(i_q_req.khz - 9'd10);
    assign limit    = (r_khz < 9'd20) ? 6'd50 : 6'd60;
    assign on_cnt   = r_scaled[RECIP_SH +: 15];
    assign out_free = !r_valid || !i_stall;
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;
    assign o_valid  = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && !i_stall && r_state != S_FIN) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_kv  <= i_q_req.kv;
                        r_khz <= i_q_req.khz;
                        if (!i_q_req.ok) begin
                            r_res_wrap  <= OFF_WRAP;
                            r_res_level <= i_inv ? OFF_LEVEL_INV : 15'd0;
                            r_res_duty  <= '0;
                            r_res_off   <= 1'b1;
                            r_state     <= S_FIN;
                        end else begin
                            r_den   <= 19'(i_q_req.khz * 19'd1000);
                            r_quo   <= i_clock_hz;
                            r_rem   <= '0;
                            r_cnt   <= '0;
                            r_hit   <= i_q_req.khz <= 9'd30;
                            r_grad  <= grad_milli(tk);
                            r_num   <= 15'(15'(i_q_req.kv) * 15'd1000)
                                       + 15'(icpt_milli(tk));
                            r_state <= S_DIVP;
                        end
                    end
                end
                S_DIVP: begin
                    r_rem <= rem_nx;
                    r_quo <= quo_nx;
                    r_cnt <= r_cnt + 1'b1;
                    if (last) begin
                        r_period <= (quo_nx == 28'd0) ? 15'd0 : 15'(quo_nx - 28'd1);
                        r_quo    <= {13'd0, r_num};
                        r_den    <= {9'd0, r_grad};
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_state  <= S_DIVD;
                    end
                end
                S_DIVD: begin
                    r_rem <= rem_nx;
                    r_quo <= quo_nx;
                    r_cnt <= r_cnt + 1'b1;
                    if (last) begin
                        if (!r_hit) r_duty <= 6'd1;
                        else if (quo_nx > 28'(limit)) r_duty <= limit;
                        else r_duty <= quo_nx[5:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= 21'(r_period) * 21'(r_duty);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_scaled <= 43'(r_prod) * 43'(RECIP_100);
                    r_state  <= S_LEVEL;
                end
                S_LEVEL: begin
                    r_res_wrap  <= r_period;
                    r_res_level <= i_inv ? 15'(r_period - on_cnt) : on_cnt;
                    r_res_duty  <= r_duty;
                    r_res_off   <= 1'b0;
                    r_state     <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        o_period_wrap   <= r_res_wrap;
                        o_compare_level <= r_res_level;
                        o_duty_percent  <= r_res_duty;
                        o_supply_off    <= r_res_off;
                        o_volts_kv      <= r_res_off ? 5'd0 : r_kv;
                        o_freq_khz      <= r_res_off ? 9'd0 : r_khz;
                        r_valid         <= 1'b1;
                        r_state         <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_load_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_valid) |-> $past(r_state) == S_FIN)
        else $error("result loaded outside finish step");

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && o_supply_off) |-> (o_duty_percent == 6'd0 && o_volts_kv == 5'd0))
        else $error("off setting carries nonzero fields");

    a_duty_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_supply_off) |-> (o_duty_percent <= 6'd60))
        else $error("duty above cap");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |=> (r_state == S_DIVP || r_state == S_FIN))
        else $error("popped request not started");

endmodule

@@ hdl/hv_supply_pwm_setpoint.sv @@
// a valid request runs two 28-step restoring divisions in one shared divider,
// then the multiply, scale and level steps; the off setting goes straight to
// the finish step; the back end takes a new request only once the last is done;
// bytes are taken one per cycle while the queue is not full, a 2-deep queue
// buffers requests
// reset (synchronous, active low): parser cleared, queue empty, no result,
// inverting_driver 1, clock_hz 125000000
module hv_supply_pwm_setpoint
    import hvps_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [14:0]       o_period_wrap,
    output logic [14:0]       o_compare_level,
    output logic [5:0]        o_duty_percent,
    output logic              o_supply_off,
    output logic [4:0]        o_volts_kv,
    output logic [8:0]        o_freq_khz,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic        r_inv;
    logic [27:0] r_clock_hz;

    logic take;
    logic push;
    t_req f_req;
    logic q_full;
    logic q_valid;
    t_req q_req;
    logic q_pop;

    assign pready  = 1'b1;
    assign o_stall = q_full;
    assign take    = i_valid && !q_full;
    assign prdata  = (paddr[2] == REG_CLK) ? {4'd0, r_clock_hz} : {31'd0, r_inv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv      <= 1'b1;
            r_clock_hz <= CLK_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_INV: r_inv      <= pwdata[0];
                REG_CLK: r_clock_hz <= pwdata[27:0];
                default: r_inv      <= r_inv;
            endcase
        end
    end

    hvps_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .o_push    (push),
        .o_req     (f_req)
    );

    hvps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_req   (f_req),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_req   (q_req)
    );

    hvps_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_inv           (r_inv),
        .i_clock_hz      (r_clock_hz),
        .i_q_valid       (q_valid),
        .i_q_req         (q_req),
        .o_q_pop         (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_period_wrap   (o_period_wrap),
        .o_compare_level (o_compare_level),
        .o_duty_percent  (o_duty_percent),
        .o_supply_off    (o_supply_off),
        .o_volts_kv      (o_volts_kv),
        .o_freq_khz      (o_freq_khz)
    );

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import hvps_pkg::*;

    typedef struct {
        logic [14:0] wrap;
        logic [14:0] level;
        logic [5:0]  duty;
        logic        off;
        logic [4:0]  kv;
        logic [8:0]  khz;
    } t_setting;

    class setpoint_board;
        bit          inv;
        logic [27:0] clk_hz;
        bit          phase;
        int unsigned v_acc, f_acc, v_cnt, f_cnt;
        bit          bad;
        t_setting    pending[$];
        int          errors;

        function void clear_parse();
            phase = 0; v_acc = 0; f_acc = 0; v_cnt = 0; f_cnt = 0; bad = 0;
        endfunction

        function void add_digit(ref int unsigned acc, ref int unsigned cnt,
                                input int unsigned d);
            int unsigned v;
            if (cnt >= MAX_DIGITS) begin
                bad = 1;
            end else begin
                cnt++;
                v = acc * 10 + d;
                acc = (v > 131071) ? 131071 : v;
            end
        endfunction

        function int unsigned duty_for(int unsigned kv, int unsigned khz);
            int unsigned gr[21] = '{787, 738, 672, 639, 618, 571, 505, 503, 457, 443,
                403, 394, 372, 354, 339, 323, 357, 346, 353, 345, 327};
            int unsigned ic[21] = '{2992, 3148, 3000, 2946, 3294, 3294, 2330, 3045,
                2259, 2244, 1505, 2161, 1650, 1442, 1412, 1483, 2594, 2436, 3067,
                2714, 2411};
            int unsigned d;
            if (khz >= 10 && khz <= 30) d = (1000 * kv + ic[khz-10]) / gr[khz-10];
            else d = 1;
            if (khz < 20) begin
                if (d > 50) d = 50;
            end else if (d > 60) d = 60;
            return d;
        endfunction

        function void note_byte(logic [7:0] c);
            t_setting s;
            int unsigned kv, khz, q, per, duty, on_cnt;
            bit ok;
            if (c != CH_H) begin
                if (c >= CH_ZERO && c <= CH_NINE) begin
                    if (!phase) add_digit(v_acc, v_cnt, c - CH_ZERO);
                    else add_digit(f_acc, f_cnt, c - CH_ZERO);
                end else if (c == CH_V && !phase) phase = 1;
                else bad = 1;
                return;
            end
            kv = v_acc; khz = f_acc;
            ok = phase && !bad && kv >= 5 && kv <= 20 && khz >= 10 && khz <= 300;
            clear_parse();
            if (!ok) begin
                s = '{OFF_WRAP, inv ? OFF_LEVEL_INV : 15'd0, 6'd0, 1'b1, 5'd0, 9'd0};
            end else begin
                q = clk_hz / (khz * 1000);
                per = (q == 0) ? 0 : q - 1;
                duty = duty_for(kv, khz);
                on_cnt = per * duty / 100;
                s.wrap = per[14:0];
                s.level = inv ? 15'(per - on_cnt) : on_cnt[14:0];
                s.duty = duty[5:0];
                s.off = 0; s.kv = kv[4:0]; s.khz = khz[8:0];
            end
            pending.push_back(s);
        endfunction

        function void check_setting(t_setting a);
            t_setting e;
            if (pending.size() == 0) begin
                $error("unexpected setting word");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (a.wrap !== e.wrap) begin
                $error("period_wrap exp %0d got %0d", e.wrap, a.wrap); errors++;
            end
            if (a.level !== e.level) begin
                $error("compare_level exp %0d got %0d", e.level, a.level); errors++;
            end
            if (a.duty !== e.duty) begin
                $error("duty_percent exp %0d got %0d", e.duty, a.duty); errors++;
            end
            if (a.off !== e.off) begin
                $error("supply_off exp %0d got %0d", e.off, a.off); errors++;
            end
            if (a.kv !== e.kv) begin
                $error("volts_kv exp %0d got %0d", e.kv, a.kv); errors++;
            end
            if (a.khz !== e.khz) begin
                $error("freq_khz exp %0d got %0d", e.khz, a.khz); errors++;
            end
        endfunction
    endclass

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_valid = 0, i_stall = 0;
    logic [7:0]  i_rx_byte = 0;
    logic        o_valid, o_stall, o_supply_off;
    logic [14:0] o_period_wrap, o_compare_level;
    logic [5:0]  o_duty_percent;
    logic [4:0]  o_volts_kv;
    logic [8:0]  o_freq_khz;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = 0;
    logic [31:0] pwdata = 0, prdata;
    logic        pready;

    int send_idle = 23, recv_idle = 76;
    setpoint_board board = new();

    hv_supply_pwm_setpoint dut (.*);

    always #2 i_clk = ~i_clk;

    // receiver: random stall, check accepted words
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            board.check_setting('{o_period_wrap, o_compare_level, o_duty_percent,
                                  o_supply_off, o_volts_kv, o_freq_khz});
        i_stall <= ($urandom_range(99) < recv_idle);
    end

    task automatic reg_write(logic [ADDR_W-1:0] idx, logic [31:0] val);
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= ADDR_W'(idx * 4); pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_INV) board.inv = val[0];
        else board.clk_hz = val[27:0];
    endtask

    task automatic send_byte(logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1; i_rx_byte <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_byte(b);
    endtask

    task automatic send_str(string s);
        foreach (s[k]) send_byte(s[k]);
    endtask

    task automatic drain();
        i_valid <= 0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic send_number(int unsigned n);
        send_str($sformatf("%0d", n));
    endtask

    // mostly well formed commands, some broken ones and noise
    task automatic random_command(ref int count);
        int kind;
        kind = $urandom_range(9);
        if (kind < 6) begin
            send_number($urandom_range(25)); send_byte(CH_V);
            if ($urandom_range(1)) send_number($urandom_range(10, 30));
            else send_number($urandom_range(320));
            send_byte(CH_H);
        end else if (kind == 6) begin
            send_number($urandom_range(999999)); send_byte(CH_V);
            send_number($urandom_range(9999999)); send_byte(CH_H);
        end else if (kind == 7) begin
            send_number($urandom_range(20)); send_byte(8'($urandom));
            send_number($urandom_range(300)); send_byte(CH_H);
        end else begin
            repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
            send_byte(CH_H);
        end
        count += 8;
    endtask

    task automatic random_phase(int n);
        int count = 0;
        while (count < n) random_command(count);
        drain();
    endtask

    initial begin
        board.inv = 1; board.clk_hz = CLK_RESET; board.clear_parse();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        send_str("10V25H"); send_str("5V10H"); send_str("20V300H");
        send_str("4V10H"); send_str("21V9H"); send_str("12H");
        send_str("V10H"); send_str("123456V10H"); send_str("10V2a5H");
        send_str("10V20V"); send_str("H"); send_byte(8'hff); send_byte(CH_H);
        drain();
        reg_write(REG_INV, 0); reg_write(REG_CLK, 1000000);
        send_str("20V19H"); send_str("15V30H"); send_str("9V12H");
        send_str("7V300H"); send_str("0V0H");
        drain();
        reg_write(REG_CLK, 250000000);
        random_phase(400);
        reg_write(REG_INV, 1); reg_write(REG_CLK, $urandom_range(1000000, 250000000));
        send_idle = 76; recv_idle = 23;
        random_phase(400);
        reg_write(REG_INV, $urandom_range(1)); reg_write(REG_CLK, 125000000);
        send_idle = 0; recv_idle = 0;
        random_phase(400);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("hv_supply_pwm_setpoint verification clean");
        else
            $display("hv_supply_pwm_setpoint verification failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("hv_supply_pwm_setpoint verification failed");
        $finish;
    end
endmodule
